// ===== rtl/bfcp_pkg.sv =====
package bfcp_pkg;

   localparam int POOL_MAX  = 64;
   localparam int ID_BITS   = 24;
   localparam int KEY_BITS  = 32;
   localparam int POS_BITS  = 7;
   localparam int IDX_BITS  = 6;
   localparam int NODE_BITS = 25;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 25;

   localparam logic [POS_BITS-1:0] POS_NONE = POS_BITS'(POOL_MAX);
   localparam logic [POS_BITS-1:0] BEAM_WIDTH_RESET = 7'd16;
   localparam logic [NODE_BITS-1:0] NODE_COUNT_RESET = 25'd16777216;

   // operation codes
   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_SEED  = 3'd1;
   localparam logic [2:0] OP_OFFER = 3'd2;
   localparam logic [2:0] OP_NEXT  = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_DUP    = 3'd1;
   localparam logic [2:0] ST_FAR    = 3'd2;
   localparam logic [2:0] ST_RANGE  = 3'd3;
   localparam logic [2:0] ST_FULL   = 3'd4;
   localparam logic [2:0] ST_EXPAND = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_BEAM_WIDTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NODE_COUNT = 2'd1;

   typedef struct packed {
      logic [2:0]          operation;
      logic [ID_BITS-1:0]  node_id;
      logic [KEY_BITS-1:0] dist_key;
      logic [IDX_BITS-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [POS_BITS-1:0] position;
      logic [ID_BITS-1:0]  out_id;
      logic [KEY_BITS-1:0] out_key;
   } rsp_type;

   typedef struct packed {
      logic [2:0]          operation;
      logic [ID_BITS-1:0]  node_id;
      logic [KEY_BITS-1:0] dist_key;
      logic [IDX_BITS-1:0] read_index;
      logic                out_of_range;
   } cmd_type;

endpackage

// ===== rtl/bfcp_front.sv =====
module bfcp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  bfcp_pkg::req_type               req_item,
   input  logic [bfcp_pkg::NODE_BITS-1:0]  node_count,
   output logic                            cmd_valid,
   input  logic                            cmd_pop,
   output bfcp_pkg::cmd_type               cmd_item
);
   import bfcp_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;
   cmd_type    cls;

   // classify on entry: decode and id range check
   always_comb begin
      cls.operation    = req_item.operation;
      cls.node_id      = req_item.node_id;
      cls.dist_key     = req_item.dist_key;
      cls.read_index   = req_item.read_index;
      cls.out_of_range = {1'b0, req_item.node_id} >= node_count;
   end

   assign req_full  = cnt_ff == 2'd2;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd_item  = q_ff[rd_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_in  = wr_ff ^ push_ok;
      rd_in  = rd_ff ^ pop_ok;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) begin
         q_ff[wr_ff] <= cls;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("command queue overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop_ok) else $error("pop from empty command queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push_ok && !pop_ok |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("command count did not grow");

endmodule

// ===== rtl/bfcp_pool.sv =====
module bfcp_pool (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bfcp_pkg::POS_BITS-1:0]  beam_width,
   input  logic                           cmd_valid,
   output logic                           cmd_pop,
   input  bfcp_pkg::cmd_type              cmd_item,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output bfcp_pkg::rsp_type              rsp_item
);
   import bfcp_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_CALC, S_APPLY} state_type;

   state_type           state_ff;
   cmd_type             cmd_ff;
   logic [POS_BITS-1:0] p_ff;
   logic                far_ff;
   logic [POS_BITS:0]   cur_ff;

   logic [ID_BITS-1:0]  ids_ff  [POOL_MAX];
   logic [KEY_BITS-1:0] keys_ff [POOL_MAX];
   logic [POOL_MAX-1:0] flag_ff;
   logic [ID_BITS-1:0]  ids_in  [POOL_MAX];
   logic [KEY_BITS-1:0] keys_in [POOL_MAX];
   logic [POOL_MAX-1:0] flag_in;
   logic [POS_BITS-1:0] fill_ff, fill_in;
   logic [POS_BITS-1:0] cursor_ff, cursor_in;
   logic [POS_BITS-1:0] lowest_ff, lowest_in;
   logic                exp_ff, exp_in;

   rsp_type             oq_ff [2];
   logic                oq_wr_ff, oq_rd_ff;
   logic [1:0]          oq_cnt_ff;
   logic                room, fire, oq_pop;

   logic [POS_BITS-1:0] k, fill_w, lim, p_calc;
   logic                far_calc;
   logic [POS_BITS:0]   cur_calc;

   logic [POS_BITS-1:0] brk, nidx;
   logic                dup, found;
   logic                ins_en;
   logic [POS_BITS-1:0] ins_lim;
   rsp_type             rsp_w;

   assign k = (beam_width == '0) ? POS_BITS'(1) :
              (beam_width > POS_NONE) ? POS_NONE : beam_width;
   assign fill_w = (fill_ff > k) ? k : fill_ff;

   assign room    = oq_cnt_ff != 2'd2;
   assign fire    = (state_ff == S_APPLY) && room;
   assign cmd_pop = cmd_valid && ((state_ff == S_IDLE) || fire);

   // first pass: sorted position, worst key check, cursor restart
   always_comb begin
      lim      = (cmd_ff.operation == OP_SEED) ? fill_w : k;
      p_calc   = POS_NONE;
      for (int i = POOL_MAX - 1; i >= 0; i--) begin
         if (POS_BITS'(i) >= lim || keys_ff[i] > cmd_ff.dist_key) begin
            p_calc = POS_BITS'(i);
         end
      end
      far_calc = cmd_ff.dist_key >= keys_ff[IDX_BITS'(k - POS_BITS'(1))];
      if (exp_ff) begin
         cur_calc = (lowest_ff <= cursor_ff) ? {1'b0, lowest_ff}
                                             : {1'b0, cursor_ff} + 1'b1;
      end else begin
         cur_calc = {1'b0, cursor_ff};
      end
   end

   // second pass: duplicate run check and flag search
   always_comb begin
      brk = '0;
      for (int j = 0; j < POOL_MAX; j++) begin
         if (POS_BITS'(j) < p_ff && keys_ff[j] != cmd_ff.dist_key) begin
            brk = POS_BITS'(j + 1);
         end
      end
      dup = 1'b0;
      for (int j = 0; j < POOL_MAX; j++) begin
         if (POS_BITS'(j) >= brk && POS_BITS'(j) < p_ff &&
             ids_ff[j] == cmd_ff.node_id) begin
            dup = 1'b1;
         end
      end
      found = 1'b0;
      nidx  = '0;
      for (int i = POOL_MAX - 1; i >= 0; i--) begin
         if ((POS_BITS+1)'(i) >= cur_ff && POS_BITS'(i) < k && flag_ff[i]) begin
            found = 1'b1;
            nidx  = POS_BITS'(i);
         end
      end
   end

   always_comb begin
      ins_en    = 1'b0;
      ins_lim   = k;
      fill_in   = fill_ff;
      cursor_in = cursor_ff;
      lowest_in = lowest_ff;
      exp_in    = exp_ff;
      flag_in   = flag_ff;
      rsp_w     = '{status: ST_OK, position: POS_NONE, out_id: '0, out_key: '0};
      for (int i = 0; i < POOL_MAX; i++) begin
         ids_in[i]  = ids_ff[i];
         keys_in[i] = keys_ff[i];
      end
      case (cmd_ff.operation)
         OP_CLEAR: begin
            for (int i = 0; i < POOL_MAX; i++) begin
               ids_in[i]  = '0;
               keys_in[i] = '1;
            end
            flag_in   = '0;
            fill_in   = '0;
            cursor_in = '0;
            lowest_in = k;
            exp_in    = 1'b0;
         end
         OP_SEED: begin
            if (cmd_ff.out_of_range) begin
               rsp_w.status = ST_RANGE;
            end else if (fill_w >= k) begin
               rsp_w.status = ST_FULL;
            end else begin
               ins_en  = 1'b1;
               ins_lim = fill_w + POS_BITS'(1);
               fill_in = fill_w + POS_BITS'(1);
               rsp_w   = '{status: ST_OK, position: p_ff,
                           out_id: cmd_ff.node_id, out_key: cmd_ff.dist_key};
            end
         end
         OP_OFFER: begin
            if (cmd_ff.out_of_range) begin
               rsp_w.status = ST_RANGE;
            end else if (far_ff) begin
               rsp_w.status = ST_FAR;
            end else if (dup) begin
               rsp_w.status = ST_DUP;
            end else begin
               ins_en  = 1'b1;
               ins_lim = k;
               fill_in = (fill_w < k) ? fill_w + POS_BITS'(1) : k;
               if (exp_ff && p_ff < lowest_ff) begin
                  lowest_in = p_ff;
               end
               rsp_w = '{status: ST_OK, position: p_ff,
                         out_id: cmd_ff.node_id, out_key: cmd_ff.dist_key};
            end
         end
         OP_NEXT: begin
            lowest_in = k;
            if (found) begin
               flag_in[nidx[IDX_BITS-1:0]] = 1'b0;
               exp_in    = 1'b1;
               cursor_in = nidx;
               rsp_w = '{status: ST_EXPAND, position: nidx,
                         out_id: ids_ff[nidx[IDX_BITS-1:0]],
                         out_key: keys_ff[nidx[IDX_BITS-1:0]]};
            end else begin
               exp_in = 1'b0;
               if (cur_ff >= {1'b0, k}) begin
                  cursor_in = (cur_ff > {1'b0, POS_NONE}) ? POS_NONE
                                                           : cur_ff[POS_BITS-1:0];
               end else begin
                  cursor_in = k;
               end
               rsp_w.status = ST_DONE;
            end
         end
         OP_READ: begin
            if ({1'b0, cmd_ff.read_index} >= k) begin
               rsp_w.status = ST_RANGE;
            end else begin
               rsp_w = '{status: ST_OK, position: {1'b0, cmd_ff.read_index},
                         out_id: ids_ff[cmd_ff.read_index],
                         out_key: keys_ff[cmd_ff.read_index]};
            end
         end
         default: begin
         end
      endcase
      // insert: entries above the slot move up one, within the limit
      if (ins_en) begin
         for (int i = 1; i < POOL_MAX; i++) begin
            if (POS_BITS'(i) > p_ff && POS_BITS'(i) < ins_lim) begin
               ids_in[i]  = ids_ff[i-1];
               keys_in[i] = keys_ff[i-1];
               flag_in[i] = flag_ff[i-1];
            end
         end
         ids_in[p_ff[IDX_BITS-1:0]]  = cmd_ff.node_id;
         keys_in[p_ff[IDX_BITS-1:0]] = cmd_ff.dist_key;
         flag_in[p_ff[IDX_BITS-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd_pop) state_ff <= S_CALC;
            end
            S_CALC: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (cmd_pop) state_ff <= S_CALC;
               else if (room) state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (cmd_pop) cmd_ff <= cmd_item;
      if (state_ff == S_CALC) begin
         p_ff   <= p_calc;
         far_ff <= far_calc;
         cur_ff <= cur_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOL_MAX; i++) begin
            ids_ff[i]  <= '0;
            keys_ff[i] <= '1;
         end
         flag_ff   <= '0;
         fill_ff   <= '0;
         cursor_ff <= '0;
         lowest_ff <= BEAM_WIDTH_RESET;
         exp_ff    <= 1'b0;
      end else if (fire) begin
         for (int i = 0; i < POOL_MAX; i++) begin
            ids_ff[i]  <= ids_in[i];
            keys_ff[i] <= keys_in[i];
         end
         flag_ff   <= flag_in;
         fill_ff   <= fill_in;
         cursor_ff <= cursor_in;
         lowest_ff <= lowest_in;
         exp_ff    <= exp_in;
      end
   end

   // result queue
   assign rsp_empty = oq_cnt_ff == 2'd0;
   assign rsp_item  = oq_ff[oq_rd_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         oq_wr_ff  <= oq_wr_ff ^ fire;
         oq_rd_ff  <= oq_rd_ff ^ oq_pop;
         oq_cnt_ff <= oq_cnt_ff + {1'b0, fire} - {1'b0, oq_pop};
      end
      if (fire) oq_ff[oq_wr_ff] <= rsp_w;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= POS_NONE && cursor_ff <= POS_NONE) else $error("fill or cursor out of bound");
   a_calc_apply: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CALC |=> state_ff == S_APPLY) else $error("calc not followed by apply");
   a_pop_state: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == S_IDLE || state_ff == S_APPLY))
      else $error("command taken while busy");
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_cnt_ff <= 2'd2) else $error("result queue overflow");

endmodule

// ===== rtl/best_first_candidate_pool_top.sv =====
// channel   | handshake                  | payload
// req_      | req_push / req_full        | req_item  (operation, node_id, dist_key, read_index)
// rsp_      | rsp_empty / rsp_pop        | rsp_item  (status, position, out_id, out_key)
// csr_      | csr_valid / csr_ready      | csr_index, csr_data
//
// The pool engine handles each item in a calc state that finds the sorted slot and the
// worst key, then an apply state that checks duplicates, scans flags and updates the entry array.
// A 2-deep command queue and a 2-deep result queue sit on either side.
// Reset is synchronous and restores the empty pool at once (no clearing pass).
// A full result queue stalls the engine; the command queue keeps taking items until it is full.
module best_first_candidate_pool_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  bfcp_pkg::req_type                   req_item,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output bfcp_pkg::rsp_type                   rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bfcp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [bfcp_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import bfcp_pkg::*;

   logic [POS_BITS-1:0]  beam_width_ff;
   logic [NODE_BITS-1:0] node_count_ff;
   logic                 cmd_valid, cmd_pop;
   cmd_type              cmd_item;

   // config writes always land; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_width_ff <= BEAM_WIDTH_RESET;
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BEAM_WIDTH: beam_width_ff <= csr_data[POS_BITS-1:0];
            CSR_NODE_COUNT: node_count_ff <= csr_data[NODE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: takes items, checks id range, queues commands
   bfcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_item   (req_item),
      .node_count (node_count_ff),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd_item   (cmd_item)
   );

   // back: sorted entry array, cursor and result queue
   bfcp_pool u_pool (
      .clock      (clock),
      .reset      (reset),
      .beam_width (beam_width_ff),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd_item   (cmd_item),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== test/tb_best_first_candidate_pool_top.sv =====
module tb_best_first_candidate_pool_top;
   import bfcp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_item = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   best_first_candidate_pool_top uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow pool: predicts one response per accepted item.
   // ---------------------------------------------------------------
   logic [6:0]          sh_beam_width;
   logic [24:0]         sh_node_count;
   logic [ID_BITS-1:0]  sh_ids [POOL_MAX];
   logic [KEY_BITS-1:0] sh_keys [POOL_MAX];
   logic                sh_flag [POOL_MAX];
   int                  sh_fill, sh_cursor, sh_lowest;
   bit                  sh_expanding;

   req_type pending_items[$];   // items the driver still has to push
   rsp_type expected_rsps[$];   // predicted responses, oldest first
   int      error_count = 0;
   int      stall_hold = 0;     // long receiver hold-off, in cycles
   bit      quiet = 1'b0;       // no random idling while set

   function automatic void queue_item(req_type it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   function automatic int pool_width();
      if (sh_beam_width < 1) return 1;
      if (sh_beam_width > POOL_MAX) return POOL_MAX;
      return int'(sh_beam_width);
   endfunction

   function automatic void empty_shadow();
      for (int i = 0; i < POOL_MAX; i++) begin
         sh_ids[i] = '0;
         sh_keys[i] = '1;
         sh_flag[i] = 1'b0;
      end
      sh_fill = 0;
      sh_cursor = 0;
      sh_lowest = pool_width();
      sh_expanding = 1'b0;
   endfunction

   function automatic void place_entry(int pos, int limit, logic [ID_BITS-1:0] id,
                                       logic [KEY_BITS-1:0] key);
      for (int i = limit - 1; i > pos; i--) begin
         sh_ids[i] = sh_ids[i-1];
         sh_keys[i] = sh_keys[i-1];
         sh_flag[i] = sh_flag[i-1];
      end
      sh_ids[pos] = id;
      sh_keys[pos] = key;
      sh_flag[pos] = 1'b1;
   endfunction

   function automatic int slot_after(int count, logic [KEY_BITS-1:0] key);
      int p;
      p = 0;
      while (p < count && sh_keys[p] <= key) p++;
      return p;
   endfunction

   function automatic rsp_type make_rsp(logic [2:0] st, int pos, logic [ID_BITS-1:0] id,
                                        logic [KEY_BITS-1:0] key);
      rsp_type r;
      r.status = st;
      r.position = POS_BITS'(pos);
      r.out_id = id;
      r.out_key = key;
      return r;
   endfunction

   function automatic rsp_type predict_pool(req_type it);
      int  k, fill, p;
      bit  dup;
      rsp_type r;
      k = pool_width();
      fill = (sh_fill > k) ? k : sh_fill;
      r = make_rsp(ST_OK, POOL_MAX, '0, '0);
      case (it.operation)
         OP_CLEAR: empty_shadow();
         OP_SEED: begin
            if ({1'b0, it.node_id} >= sh_node_count) r.status = ST_RANGE;
            else if (fill >= k) r.status = ST_FULL;
            else begin
               p = slot_after(fill, it.dist_key);
               place_entry(p, fill + 1, it.node_id, it.dist_key);
               sh_fill = fill + 1;
               r = make_rsp(ST_OK, p, it.node_id, it.dist_key);
            end
         end
         OP_OFFER: begin
            if ({1'b0, it.node_id} >= sh_node_count) r.status = ST_RANGE;
            else if (it.dist_key >= sh_keys[k-1]) r.status = ST_FAR;
            else begin
               dup = 1'b0;
               p = slot_after(k, it.dist_key);
               for (int i = p; i > 0; i--) begin
                  if (sh_keys[i-1] != it.dist_key) break;
                  if (sh_ids[i-1] == it.node_id) begin
                     dup = 1'b1;
                     break;
                  end
               end
               if (dup) r.status = ST_DUP;
               else begin
                  place_entry(p, k, it.node_id, it.dist_key);
                  sh_fill = (fill < k) ? fill + 1 : k;
                  if (sh_expanding && p < sh_lowest) sh_lowest = p;
                  r = make_rsp(ST_OK, p, it.node_id, it.dist_key);
               end
            end
         end
         OP_NEXT: begin
            // restart rule: jump back to the lowest insert if it is behind us
            if (sh_expanding) begin
               if (sh_lowest <= sh_cursor) sh_cursor = sh_lowest;
               else sh_cursor = sh_cursor + 1;
               sh_expanding = 1'b0;
            end
            sh_lowest = k;
            while (sh_cursor < k && !sh_flag[sh_cursor]) sh_cursor++;
            if (sh_cursor >= k) begin
               if (sh_cursor > POOL_MAX) sh_cursor = POOL_MAX;
               r.status = ST_DONE;
            end else begin
               sh_flag[sh_cursor] = 1'b0;
               sh_expanding = 1'b1;
               r = make_rsp(ST_EXPAND, sh_cursor, sh_ids[sh_cursor], sh_keys[sh_cursor]);
            end
         end
         OP_READ: begin
            if (it.read_index >= k) r.status = ST_RANGE;
            else r = make_rsp(ST_OK, int'(it.read_index), sh_ids[it.read_index],
                              sh_keys[it.read_index]);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // ---------------------------------------------------------------
   // Driver: one nonblocking assignment per signal per edge.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            expected_rsps.insert(expected_rsps.size(), predict_pool(req_item));
            void'(pending_items.pop_front());
         end
         if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
            req_push <= 1'b1;
            req_item <= pending_items[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: checks and pops responses.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected item", 64'(rsp_item.out_key), '0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_item.status !== want.status)
                  report_mismatch("status", 64'(rsp_item.status), 64'(want.status));
               if (rsp_item.position !== want.position)
                  report_mismatch("position", 64'(rsp_item.position), 64'(want.position));
               if (rsp_item.out_id !== want.out_id)
                  report_mismatch("out_id", 64'(rsp_item.out_id), 64'(want.out_id));
               if (rsp_item.out_key !== want.out_key)
                  report_mismatch("out_key", 64'(rsp_item.out_key), 64'(want.out_key));
            end
         end
         if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= quiet || ($urandom_range(99) >= 17);
         end
      end
   end

   // Register write while idle; shadow copy follows the accepted write.
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_BEAM_WIDTH) sh_beam_width = val[6:0];
      else if (idx == CSR_NODE_COUNT) sh_node_count = val;
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic req_type make_req(logic [2:0] op, logic [ID_BITS-1:0] id,
                                        logic [KEY_BITS-1:0] key, logic [IDX_BITS-1:0] idx);
      req_type it;
      it.operation = op;
      it.node_id = id;
      it.dist_key = key;
      it.read_index = idx;
      return it;
   endfunction

   // key drawn from a narrow band now and then so equal keys occur
   function automatic logic [KEY_BITS-1:0] pick_key();
      case ($urandom_range(3))
         0: return KEY_BITS'($urandom_range(15));
         1: return $urandom_range(1) ? '1 : {KEY_BITS{1'b1}} - 1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [ID_BITS-1:0] pick_id();
      if ($urandom_range(3) == 0) return ID_BITS'($urandom_range(7));
      return ID_BITS'($urandom());
   endfunction

   // one search: clear, seeds, then next/offer rounds, reads and random opcodes mixed in
   task automatic queue_search(int width);
      queue_item(make_req(OP_CLEAR, '0, '0, '0));
      repeat ($urandom_range(1, width + 1))
         queue_item(make_req(OP_SEED, pick_id(), pick_key(), '0));
      repeat ($urandom_range(2, 10)) begin
         queue_item(make_req(OP_NEXT, '0, '0, '0));
         repeat ($urandom_range(0, 4))
            queue_item(make_req(OP_OFFER, pick_id(), pick_key(), '0));
         if ($urandom_range(4) == 0)
            queue_item(make_req(OP_READ, '0, '0, IDX_BITS'($urandom())));
         if ($urandom_range(9) == 0)
            queue_item(make_req(3'($urandom_range(7)), ID_BITS'($urandom()), $urandom(),
                                IDX_BITS'($urandom())));
      end
   endtask

   initial begin
      int sizes[6] = '{16, 1, 64, 5, 0, 127};
      sh_beam_width = BEAM_WIDTH_RESET;
      sh_node_count = NODE_COUNT_RESET;
      empty_shadow();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: every op but clear, undefined codes, field extremes, duplicates, full, range, done
      queue_item(make_req(OP_NEXT, '0, '0, '0));
      queue_item(make_req(OP_SEED, '1, '0, '0));
      queue_item(make_req(OP_SEED, 24'd5, 32'd100, '0));
      queue_item(make_req(OP_SEED, 24'd6, 32'd100, '0));
      queue_item(make_req(OP_SEED, '0, '0, '0));
      queue_item(make_req(OP_OFFER, 24'd6, 32'd100, '0));
      queue_item(make_req(OP_OFFER, 24'd7, 32'd100, '0));
      queue_item(make_req(OP_OFFER, 24'd9, '1, '0));
      queue_item(make_req(OP_NEXT, '0, '0, '0));
      queue_item(make_req(OP_NEXT, '0, '0, '0));
      queue_item(make_req(OP_OFFER, 24'd8, 32'd1, '0));
      queue_item(make_req(OP_NEXT, '0, '0, '0));
      queue_item(make_req(OP_READ, '0, '0, '0));
      queue_item(make_req(OP_READ, '0, '0, '1));
      queue_item(make_req(3'd7, '1, '1, '1));
      queue_item(make_req(3'd5, '0, '0, '0));
      repeat (20) queue_item(make_req(OP_SEED, ID_BITS'($urandom()), $urandom(), '0));
      repeat (20) queue_item(make_req(OP_NEXT, '0, '0, '0));
      drain();

      // node_count extremes: reject everything, then a tiny range
      write_reg(CSR_NODE_COUNT, '0);
      queue_item(make_req(OP_SEED, '0, 32'd3, '0));
      queue_item(make_req(OP_OFFER, '0, 32'd3, '0));
      drain();
      write_reg(CSR_NODE_COUNT, 25'd8);
      queue_search(16);
      drain();
      write_reg(CSR_NODE_COUNT, NODE_COUNT_RESET);

      // random searches over several pool sizes, including clamped ones
      foreach (sizes[s]) begin
         write_reg(CSR_BEAM_WIDTH, CSR_DATA_BITS'(sizes[s]));
         // long stretch with no idling on the first size
         quiet = (s == 0);
         while (pending_items.size() < 150) queue_search(sizes[s] > 20 ? 20 : sizes[s]);
         if (s == 2) stall_hold <= 300;  // receiver holds off; input fills and stalls
         drain();
         quiet = 1'b0;
      end

      // size change mid-search without clear (entries beyond the size ignored)
      write_reg(CSR_BEAM_WIDTH, 25'd40);
      queue_search(40);
      drain();
      write_reg(CSR_BEAM_WIDTH, 25'd3);
      repeat (10) queue_item(make_req(OP_NEXT, '0, '0, '0));
      queue_item(make_req(OP_READ, '0, '0, 6'd2));
      drain();

      if (error_count == 0) $display("tb_best_first_candidate_pool_top: done, clean");
      else $display("tb_best_first_candidate_pool_top: done, errors");
      $finish;
   end

   initial begin
      #20000000;
      $display("tb_best_first_candidate_pool_top: done, errors");
      $finish;
   end

endmodule
